FILE: src/indexed_list_insert_delete_assert.svh
// Assertion macros for the indexed list block.
`ifndef INDEXED_LIST_INSERT_DELETE_ASSERT_SVH
`define INDEXED_LIST_INSERT_DELETE_ASSERT_SVH
`ifndef SYNTHESIS
`define ILD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ILD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ILD_ASSERT_ALWAYS(lbl, prop, msg)
`define ILD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: src/ild_pkg.sv
// Package with field widths, operation and status codes and controller states.
package ild_pkg;

  localparam int CAPACITY_DEF = 1024;
  localparam int KIND_W = 3;
  localparam int POS_W = 12;
  localparam int VAL_W = 32;
  localparam int STAT_W = 2;
  localparam int LEN_W = 11;

  typedef enum logic [KIND_W-1:0] {
    KIND_READ = 3'd0,
    KIND_INS_HEAD = 3'd1,
    KIND_INS_TAIL = 3'd2,
    KIND_INS_AT = 3'd3,
    KIND_DELETE = 3'd4
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MOVE,
    S_PUT,
    S_FIN
  } state_t;

endpackage

FILE: src/ild_req_if.sv
// Request channel: operation kind, position and value.
interface ild_req_if import ild_pkg::*; ;
  logic valid;
  logic ready;
  logic [KIND_W-1:0] kind;
  logic signed [POS_W-1:0] position;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, output kind, output position, output value, input ready);
  modport sink (input valid, input kind, input position, input value, output ready);
endinterface

FILE: src/ild_rsp_if.sv
// Response channel: read value, status and list length.
interface ild_rsp_if import ild_pkg::*; ;
  logic valid;
  logic ready;
  logic signed [VAL_W-1:0] read_value;
  logic [STAT_W-1:0] status;
  logic [LEN_W-1:0] length;

  modport source (output valid, output read_value, output status, output length, input ready);
  modport sink (input valid, input read_value, input status, input length, output ready);
endinterface

FILE: src/indexed_list_insert_delete.sv
// Top level of the indexed list: controller, element store and assertions.
`include "indexed_list_insert_delete_assert.svh"

// Ordered list of up to CAPACITY signed 32-bit values held packed in a single
// memory with one write and one read port. One word is taken at a time; a new
// request word is accepted while the previous response still waits on rsp.
// A read, an ignored operation or a dropped insert goes from acceptance
// through the finishing state to its response. For an insert before position
// p or a delete at p, every later entry is first moved one place through the
// memory, one entry per cycle, and an insert then writes its new value at p.
// The store needs no clearing after reset; only written entries are ever read.
module indexed_list_insert_delete import ild_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input logic       clk,
  input logic       rst,
  ild_req_if.sink   req,
  ild_rsp_if.source rsp
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  logic signed [VAL_W-1:0] mem_wdata;
  logic                    mem_re;
  logic [AW-1:0]           mem_raddr;
  logic signed [VAL_W-1:0] mem_rdata;
  logic                    rw_same;
  logic                    full_short;

  ild_ctrl #(
    .CAPACITY(CAPACITY),
    .AW(AW),
    .CW(CW)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp),
    .mem_we(mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_re(mem_re),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  ild_mem #(
    .CAPACITY(CAPACITY),
    .AW(AW)
  ) u_mem (
    .clk(clk),
    .we(mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re(mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign rw_same = mem_we && mem_re && (mem_waddr == mem_raddr);
  assign full_short = rsp.valid && (rsp.status == ST_FULL) && (rsp.length != LEN_W'(CAPACITY));

  `ILD_ASSERT_ALWAYS(a_no_same_entry, !rw_same, "read and write hit one entry")
  `ILD_ASSERT_ALWAYS(a_write_busy, !mem_we || !req.ready, "store written while idle")
  `ILD_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready, "accepted twice in a row")
  `ILD_ASSERT_ALWAYS(a_full_length, !full_short, "full status with short list")

endmodule

FILE: src/ild_mem.sv
// Element store: one write port and one read port with registered read data.
module ild_mem import ild_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int AW = $clog2(CAPACITY)
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [AW-1:0]           waddr,
  input  logic signed [VAL_W-1:0] wdata,
  input  logic                    re,
  input  logic [AW-1:0]           raddr,
  output logic signed [VAL_W-1:0] rdata
);

  logic signed [VAL_W-1:0] store [CAPACITY];

  always_ff @(posedge clk) begin
    if (we) begin
      store[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= store[raddr];
    end
  end

endmodule

FILE: src/ild_ctrl.sv
// Sequencer that decodes each operation, shifts entries and issues the response.
module ild_ctrl import ild_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int AW = $clog2(CAPACITY),
  parameter int CW = $clog2(CAPACITY + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  ild_req_if.sink                 req,
  ild_rsp_if.source               rsp,
  output logic                    mem_we,
  output logic [AW-1:0]           mem_waddr,
  output logic signed [VAL_W-1:0] mem_wdata,
  output logic                    mem_re,
  output logic [AW-1:0]           mem_raddr,
  input  logic signed [VAL_W-1:0] mem_rdata
);

  localparam int CMPW = (CW > POS_W - 1) ? CW : POS_W - 1;

  state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic ins, ins_next;
  logic [AW-1:0] ins_pos, ins_pos_next;
  logic signed [VAL_W-1:0] ins_value, ins_value_next;
  logic [AW-1:0] src, src_next;
  logic [CW-1:0] mv_left, mv_left_next;
  logic wb_valid, wb_valid_next;
  logic [AW-1:0] wb_addr, wb_addr_next;
  status_t res_status, res_status_next;
  logic res_hit, res_hit_next;
  logic res_miss, res_miss_next;
  logic rsp_valid, rsp_valid_next;
  logic signed [VAL_W-1:0] rsp_value, rsp_value_next;
  logic [STAT_W-1:0] rsp_status, rsp_status_next;
  logic [LEN_W-1:0] rsp_length, rsp_length_next;

  logic pos_neg;
  logic [CMPW-1:0] pos_ext;
  logic [CMPW-1:0] cnt_ext;
  logic in_range;
  logic up_to_end;
  logic full;
  logic [AW-1:0] pos_a;
  logic [AW-1:0] cnt_a;
  logic [CW-1:0] cnt_m1;
  logic [AW-1:0] tgt;
  logic tgt_bad;

  assign pos_neg = req.position[POS_W-1];
  assign pos_ext = CMPW'(req.position[POS_W-2:0]);
  assign cnt_ext = CMPW'(count);
  assign in_range = !pos_neg && (pos_ext < cnt_ext);
  assign up_to_end = !pos_neg && (pos_ext <= cnt_ext);
  assign full = (count == CW'(CAPACITY));
  assign pos_a = AW'(pos_ext);
  assign cnt_a = AW'(count);
  assign cnt_m1 = count - CW'(1);

  always_comb begin
    tgt = '0;
    tgt_bad = 1'b0;
    case (kind_t'(req.kind))
      KIND_INS_TAIL: begin
        tgt = cnt_a;
      end
      KIND_INS_AT: begin
        if (pos_neg) begin
          tgt = '0;
        end else if (!up_to_end) begin
          tgt_bad = 1'b1;
        end else begin
          tgt = pos_a;
        end
      end
      default: begin
        tgt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      wb_valid <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      wb_valid <= wb_valid_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    ins <= ins_next;
    ins_pos <= ins_pos_next;
    ins_value <= ins_value_next;
    src <= src_next;
    mv_left <= mv_left_next;
    wb_addr <= wb_addr_next;
    res_status <= res_status_next;
    res_hit <= res_hit_next;
    res_miss <= res_miss_next;
    rsp_value <= rsp_value_next;
    rsp_status <= rsp_status_next;
    rsp_length <= rsp_length_next;
  end

  always_comb begin
    state_next = state;
    count_next = count;
    ins_next = ins;
    ins_pos_next = ins_pos;
    ins_value_next = ins_value;
    src_next = src;
    mv_left_next = mv_left;
    wb_valid_next = wb_valid;
    wb_addr_next = wb_addr;
    res_status_next = res_status;
    res_hit_next = res_hit;
    res_miss_next = res_miss;
    rsp_value_next = rsp_value;
    rsp_status_next = rsp_status;
    rsp_length_next = rsp_length;
    rsp_valid_next = rsp_valid && !rsp.ready;
    req.ready = 1'b0;
    mem_we = 1'b0;
    mem_waddr = wb_addr;
    mem_wdata = mem_rdata;
    mem_re = 1'b0;
    mem_raddr = src;

    case (state)
      S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          res_hit_next = 1'b0;
          res_miss_next = 1'b0;
          res_status_next = ST_DONE;
          ins_value_next = req.value;
          wb_valid_next = 1'b0;
          state_next = S_FIN;
          case (kind_t'(req.kind))
            KIND_READ: begin
              if (in_range) begin
                mem_re = 1'b1;
                mem_raddr = pos_a;
                res_hit_next = 1'b1;
              end else begin
                res_miss_next = 1'b1;
                res_status_next = ST_RANGE;
              end
            end
            KIND_INS_HEAD, KIND_INS_TAIL, KIND_INS_AT: begin
              if (tgt_bad) begin
                res_status_next = ST_RANGE;
              end else if (full) begin
                res_status_next = ST_FULL;
              end else begin
                ins_next = 1'b1;
                ins_pos_next = tgt;
                src_next = AW'(cnt_m1);
                mv_left_next = count - CW'(tgt);
                count_next = count + CW'(1);
                state_next = S_MOVE;
              end
            end
            KIND_DELETE: begin
              if (in_range) begin
                ins_next = 1'b0;
                src_next = pos_a + AW'(1);
                mv_left_next = cnt_m1 - CW'(pos_a);
                count_next = cnt_m1;
                state_next = S_MOVE;
              end else begin
                res_status_next = ST_RANGE;
              end
            end
            default: begin
              res_status_next = ST_RANGE;
            end
          endcase
        end
      end
      S_MOVE: begin
        mem_we = wb_valid;
        if (mv_left != '0) begin
          mem_re = 1'b1;
          mem_raddr = src;
          src_next = ins ? src - AW'(1) : src + AW'(1);
          mv_left_next = mv_left - CW'(1);
          wb_valid_next = 1'b1;
          wb_addr_next = ins ? src + AW'(1) : src - AW'(1);
        end else begin
          wb_valid_next = 1'b0;
          if (!wb_valid) begin
            state_next = ins ? S_PUT : S_FIN;
          end
        end
      end
      S_PUT: begin
        mem_we = 1'b1;
        mem_waddr = ins_pos;
        mem_wdata = ins_value;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (!rsp_valid || rsp.ready) begin
          rsp_valid_next = 1'b1;
          rsp_value_next = res_hit ? mem_rdata : (res_miss ? '1 : '0);
          rsp_status_next = res_status;
          rsp_length_next = LEN_W'(count);
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign rsp.valid = rsp_valid;
  assign rsp.read_value = rsp_value;
  assign rsp.status = rsp_status;
  assign rsp.length = rsp_length;

endmodule
